>>> rtl/iso_date_to_epoch_days_top_assert.svh
// assertion macros for the date to epoch-days converter
// used by the port checker; depends on nothing
`ifndef ISO_DATE_TO_EPOCH_DAYS_TOP_ASSERT_SVH
`define ISO_DATE_TO_EPOCH_DAYS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IDTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IDTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/idtd_pkg.sv
// shared types, constants and the month table of the date converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package idtd_pkg;

  // request and result payloads
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } req_t;

  typedef struct packed {
    logic signed [22:0] epoch_days;
    logic               malformed;
  } rsp_t;

  // one parsed date handed from the parser to the day calculator
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        bad;
  } job_t;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [3:0] POS_DASH_A = 4'd4;
  localparam logic [3:0] POS_DASH_B = 4'd7;
  localparam logic [3:0] POS_MONTH  = 4'd5;
  localparam logic [3:0] POS_LAST   = 4'd9;
  localparam logic [3:0] DATE_LEN   = 4'd10;
  localparam logic [3:0] POS_SAT    = 4'd11;

  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;

  localparam logic signed [22:0] DAYS_PER_ERA = 23'sd146097;
  localparam logic signed [22:0] EPOCH_SHIFT  = 23'sd719468;

  // first day of month within the march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/idtd_queue.sv
// small fifo of parsed dates between parser and day calculator
// depends on idtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module idtd_queue
  import idtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/idtd_front.sv
// character parser: checks the text layout and collects year, month, day
// depends on idtd_pkg; feeds idtd_queue
`timescale 1ns / 1ps
`default_nettype none

module idtd_front
  import idtd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      job_valid,
  input  wire logic job_ready,
  output job_t      job_data
);

  logic [3:0]  position;
  logic [13:0] year_acc;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic        bad_seen;

  logic [3:0]  position_next;
  logic [13:0] year_next;
  logic [6:0]  month_next;
  logic [6:0]  day_next;
  logic        bad_next;
  logic        is_digit;
  logic [3:0]  dv;
  logic        accept;
  logic        final_bad;

  // hold characters while the date queue is full
  assign req_ready = job_ready;
  assign accept    = req_valid && req_ready;

  // classify the character at the current position
  always_comb begin
    is_digit      = (req_data.char_code >= CHAR_ZERO) && (req_data.char_code <= CHAR_NINE);
    dv            = is_digit ? 4'(req_data.char_code - CHAR_ZERO) : 4'd0;
    year_next     = year_acc;
    month_next    = month_acc;
    day_next      = day_acc;
    bad_next      = bad_seen;
    position_next = (position < POS_SAT) ? position + 4'd1 : position;
    priority if (position >= DATE_LEN) begin
      bad_next = 1'b1;
    end else if (position == POS_DASH_A || position == POS_DASH_B) begin
      if (req_data.char_code != CHAR_DASH) begin
        bad_next = 1'b1;
      end
    end else if (!is_digit) begin
      bad_next = 1'b1;
    end else if (position < POS_DASH_A) begin
      year_next = 14'(year_acc * 14'd10 + 14'(dv));
    end else if (position < POS_DASH_B) begin
      month_next = 7'(month_acc * 7'd10 + 7'(dv));
    end else begin
      day_next = 7'(day_acc * 7'd10 + 7'(dv));
    end
  end

  // final verdict on the last character
  assign final_bad = bad_next || (position != POS_LAST)
                     || (month_next == 7'd0) || (month_next > MONTH_MAX)
                     || (day_next == 7'd0) || (day_next > DAY_MAX);

  assign job_valid      = accept && req_data.last_char;
  assign job_data.year  = year_next;
  assign job_data.month = month_next[3:0];
  assign job_data.day   = day_next[4:0];
  assign job_data.bad   = final_bad;

  // parser state, cleared after every date
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      year_acc  <= '0;
      month_acc <= '0;
      day_acc   <= '0;
      bad_seen  <= 1'b0;
    end else if (accept) begin
      if (req_data.last_char) begin
        position  <= '0;
        year_acc  <= '0;
        month_acc <= '0;
        day_acc   <= '0;
        bad_seen  <= 1'b0;
      end else begin
        position  <= position_next;
        year_acc  <= year_next;
        month_acc <= month_next;
        day_acc   <= day_next;
        bad_seen  <= bad_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/idtd_back.sv
// day calculator: proleptic gregorian day count in a short step sequence
// depends on idtd_pkg; fed by idtd_queue
`timescale 1ns / 1ps
`default_nettype none

module idtd_back
  import idtd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire job_t job_data,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERA  = 3'd1;
  localparam logic [2:0] ST_YOE  = 3'd2;
  localparam logic [2:0] ST_DOE  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]         state;
  logic signed [14:0] yr;
  logic [3:0]         mp;
  logic [4:0]         dd;
  logic signed [5:0]  era;
  logic [8:0]         yoe;
  logic [8:0]         doy;
  logic [17:0]        part;
  logic [1:0]         cent;
  logic [17:0]        doe;
  logic signed [22:0] era_days;
  rsp_t               res;

  logic [20:0]        era_prod;
  logic signed [14:0] yoe_full;
  logic [14:0]        cent_prod;

  assign job_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_OUT);
  assign rsp_data  = res;

  // year / 400 as (year / 16) * 1311 >> 15, exact for years below 10000
  assign era_prod  = 21'(yr[13:4] * 11'd1311);
  assign yoe_full  = yr - 15'($signed({{9{era[5]}}, era}) * 15'sd400);
  // yoe / 100 as yoe * 41 >> 12, exact below 400
  assign cent_prod = 15'(yoe * 6'd41);

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= job_data.bad ? ST_OUT : ST_ERA;
          end
        end
        ST_ERA:  state <= ST_YOE;
        ST_YOE:  state <= ST_DOE;
        ST_DOE:  state <= ST_SUM;
        ST_SUM:  state <= ST_FIN;
        ST_FIN:  state <= ST_OUT;
        ST_OUT: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          // january and february count as the end of the previous year
          yr <= $signed({1'b0, job_data.year}) - ((job_data.month <= 4'd2) ? 15'sd1 : 15'sd0);
          mp <= (job_data.month > 4'd2) ? job_data.month - 4'd3 : job_data.month + 4'd9;
          dd <= job_data.day;
          res.epoch_days <= '0;
          res.malformed  <= job_data.bad;
        end
      end
      ST_ERA: begin
        era <= yr[14] ? -6'sd1 : $signed({1'b0, era_prod[19:15]});
      end
      ST_YOE: begin
        yoe <= yoe_full[8:0];
        doy <= month_start(mp) + 9'(dd) - 9'd1;
      end
      ST_DOE: begin
        part <= 18'(yoe * 9'd365) + 18'(doy);
        cent <= cent_prod[13:12];
      end
      ST_SUM: begin
        doe      <= part + 18'(yoe[8:2]) - 18'(cent);
        era_days <= 23'($signed({{17{era[5]}}, era}) * DAYS_PER_ERA);
      end
      ST_FIN: begin
        res.epoch_days <= era_days + $signed({5'd0, doe}) - EPOCH_SHIFT;
        res.malformed  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/iso_date_to_epoch_days_top.sv
// channel   | valid     | ready     | payload
// request   | req_valid | req_ready | req_data (char_code, last_char)
// result    | rsp_valid | rsp_ready | rsp_data (epoch_days, malformed)
//
// one character a cycle while the date queue has room; a date completes on the character flagged last.
// a good date passes the calculator steps era, yoe, doe, sum and fin before its result is offered,
// a malformed one goes straight to the result, plus the handshake; the parser runs ahead.
// a full date queue stalls the request side; a held result stalls the calculator.
// reset is synchronous; it clears parser, queue and calculator state.
//
// top level: parser, date queue and day calculator; depends on idtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module iso_date_to_epoch_days_top
  import idtd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp_data
);

  logic fq_valid;
  logic fq_ready;
  job_t fq_data;
  logic qb_valid;
  logic qb_ready;
  job_t qb_data;

  // parser
  idtd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  // date queue
  idtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // day calculator
  idtd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

>>> rtl/idtd_checker.sv
// port checker for the date converter, bound to the top level
// depends on idtd_pkg and iso_date_to_epoch_days_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "iso_date_to_epoch_days_top_assert.svh"

module idtd_checker
  import idtd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);

  logic rsp_stall;
  logic rsp_in_range;

  assign rsp_stall    = rsp_valid && !rsp_ready;
  assign rsp_in_range = (rsp_data.epoch_days >= -23'sd719528)
                        && (rsp_data.epoch_days <= 23'sd2932896);

  // malformed results carry zero days
  `IDTD_ASSERT_NOW(a_bad_zero, clk, rst, rsp_valid && rsp_data.malformed, rsp_data.epoch_days == '0, "malformed result with nonzero days")
  // good results stay within year 0 to year 9999
  `IDTD_ASSERT_NOW(a_days_range, clk, rst, rsp_valid && !rsp_data.malformed, rsp_in_range, "day count out of range")
  // a stalled result stays offered
  `IDTD_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid, "result dropped while stalled")
  // and keeps its payload
  `IDTD_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_stall, $stable(rsp_data), "result changed while stalled")

endmodule

bind iso_date_to_epoch_days_top idtd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/sv/iso_date_to_epoch_days_top_tb.sv
// testbench for the date text to epoch-days converter: directed date table,
// then random dates, broken dates and noise, all checked by a local date parser
// depends on idtd_pkg and iso_date_to_epoch_days_top
`timescale 1ns / 1ps

module iso_date_to_epoch_days_top_tb;
  import idtd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_CHARS = 1230;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  iso_date_to_epoch_days_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always #5 clk = ~clk;

  // run limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("iso_date_to_epoch_days_top_tb NOT OK");
      $finish;
    end
  end

  // parser state of the local date model
  logic [3:0]  char_idx   = '0;
  logic [13:0] year_val   = '0;
  logic [6:0]  month_val  = '0;
  logic [6:0]  day_val    = '0;
  logic        text_bad   = 1'b0;

  rsp_t pending_dates[$];
  int   errors = 0;
  int   chars_sent = 0;

  // typed-in result for the directed row in flight
  logic typed_valid = 1'b0;
  rsp_t typed_rsp;

  // proleptic gregorian day count relative to 1970-01-01
  function automatic int days_since_epoch(input int y, input int m, input int d);
    int era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // advance the parser by one accepted character
  task automatic parse_char(input req_t r, output logic done, output rsp_t res);
    logic [3:0] idx;
    logic       is_digit;
    logic [7:0] dv;
    logic       fail;
    idx      = char_idx;
    is_digit = (r.char_code >= CHAR_ZERO) && (r.char_code <= CHAR_NINE);
    dv       = is_digit ? r.char_code - CHAR_ZERO : 8'd0;
    done     = 1'b0;
    res      = '0;
    if (idx >= DATE_LEN) begin
      text_bad = 1'b1;
    end else if (idx == POS_DASH_A || idx == POS_DASH_B) begin
      if (r.char_code != CHAR_DASH) text_bad = 1'b1;
    end else if (!is_digit) begin
      text_bad = 1'b1;
    end else if (idx < POS_DASH_A) begin
      year_val = 14'(year_val * 10 + dv);
    end else if (idx < POS_DASH_B) begin
      month_val = 7'(month_val * 10 + dv);
    end else begin
      day_val = 7'(day_val * 10 + dv);
    end
    if (char_idx < POS_SAT) char_idx = char_idx + 4'd1;
    if (r.last_char) begin
      fail = text_bad || (idx != POS_LAST) || (month_val < 7'd1) || (month_val > MONTH_MAX)
             || (day_val < 7'd1) || (day_val > DAY_MAX);
      done = 1'b1;
      res.malformed  = fail;
      res.epoch_days = fail ? 23'sd0
                            : 23'(days_since_epoch(int'(year_val), int'(month_val),
                                                   int'(day_val)));
      char_idx  = '0;
      year_val  = '0;
      month_val = '0;
      day_val   = '0;
      text_bad  = 1'b0;
    end
  endtask

  // sample both channels mid-cycle; inputs only move at the rising edge
  always @(negedge clk) begin : watch
    logic done;
    rsp_t res;
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        parse_char(req_data, done, res);
        if (done) begin
          if (typed_valid) begin
            pending_dates = {pending_dates, typed_rsp};
            typed_valid = 1'b0;
          end else begin
            pending_dates = {pending_dates, res};
          end
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_dates.size() == 0) begin
          errors++;
          $display("%0t: unexpected result epoch_days %0d malformed %0b", $time,
                   $signed(rsp_data.epoch_days), rsp_data.malformed);
        end else begin
          want = pending_dates.pop_front();
          if (rsp_data.epoch_days !== want.epoch_days) begin
            errors++;
            $display("%0t: epoch_days expected %0d got %0d", $time,
                     $signed(want.epoch_days), $signed(rsp_data.epoch_days));
          end
          if (rsp_data.malformed !== want.malformed) begin
            errors++;
            $display("%0t: malformed expected %0b got %0b", $time,
                     want.malformed, rsp_data.malformed);
          end
        end
      end
    end
  end

  // result side back-pressure, with one long hold-off on request
  logic hold_off_go   = 1'b0;
  logic hold_off_done = 1'b0;
  int   hold_left = 0;
  int   mode_left = 0;
  int   mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(1, 40);
          mode = $urandom_range(0, 9);
        end
        mode_left--;
        if (mode < 3) rsp_ready <= 1'b1;
        else if (mode < 9) rsp_ready <= ($urandom_range(0, 3) != 0);
        else rsp_ready <= 1'b0;
      end
    end
  end

  // request side gaps
  logic req_burst = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (req_burst || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] noise_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return CHAR_DASH;
    if (r < 6) return CHAR_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  // one request; valid stays up until it is taken
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    req_valid <= 1'b1;
    req_data  <= '{char_code: c, last_char: lst};
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    chars_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  // stop sending until every date has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    string text;
    bit    typed;
    int    days;
    bit    bad;
  } date_row_t;

  date_row_t date_rows[$];

  initial begin : stim
    logic [7:0] txt[$];
    int start_chars, texts, y, m, d, div, k, n;
    date_rows = '{
      '{"1970-01-01", 1, 0, 0},
      '{"0000-01-01", 1, -719528, 0},
      '{"9999-12-31", 1, 2932896, 0},
      '{"1969-12-31", 1, -1, 0},
      '{"0000-02-29", 0, 0, 0},
      '{"2000-02-29", 0, 0, 0},
      '{"2021-02-31", 0, 0, 0},
      '{"1600-03-01", 0, 0, 0},
      '{"2400-12-31", 0, 0, 0},
      '{"2024-00-10", 1, 0, 1},
      '{"2024-13-10", 1, 0, 1},
      '{"2024-05-00", 1, 0, 1},
      '{"2024-05-32", 1, 0, 1},
      '{"9999-99-99", 1, 0, 1},
      '{"2024/05/10", 1, 0, 1},
      '{"20a4-05-10", 1, 0, 1},
      '{"2024-0-510", 1, 0, 1},
      '{"\377999-12-31", 1, 0, 1},
      '{"2024-05-1", 1, 0, 1},
      '{"7", 1, 0, 1},
      '{"2024-05-100", 1, 0, 1},
      '{"1999-12-31xxxxxxxxxx", 1, 0, 1}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (date_rows[i]) begin
      txt = {};
      for (int j = 0; j < date_rows[i].text.len(); j++) txt = {txt, date_rows[i].text[j]};
      if (date_rows[i].typed) begin
        typed_rsp.epoch_days = 23'(date_rows[i].days);
        typed_rsp.malformed  = date_rows[i].bad;
        typed_valid = 1'b1;
      end
      req_burst = (i % 4 == 3);
      send_text(txt);
    end
    wait_drained();

    // random dates; the first ones go out back to back under the hold-off
    hold_off_go = 1'b1;
    start_chars = chars_sent;
    texts = 0;
    while (chars_sent - start_chars < RANDOM_CHARS) begin
      req_burst = (texts < 30) || ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 99);
      txt = {};
      if (k < 85) begin
        y = $urandom_range(0, 9);
        y = (y == 0) ? 0 : (y == 1) ? 9999 : $urandom_range(0, 9999);
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        div = 1000;
        repeat (4) begin
          txt = {txt, 8'(CHAR_ZERO + 8'((y / div) % 10))};
          div /= 10;
        end
        txt = {txt, CHAR_DASH};
        txt = {txt, 8'(CHAR_ZERO + 8'(m / 10))};
        txt = {txt, 8'(CHAR_ZERO + 8'(m % 10))};
        txt = {txt, CHAR_DASH};
        txt = {txt, 8'(CHAR_ZERO + 8'(d / 10))};
        txt = {txt, 8'(CHAR_ZERO + 8'(d % 10))};
        // broken variants of a good date
        if (k >= 70) begin
          n = $urandom_range(0, 2);
          if (n == 0) begin
            txt[$urandom_range(0, 9)] = noise_char();
          end else if (n == 1) begin
            n = $urandom_range(1, 9);
            while (txt.size() > n) void'(txt.pop_back());
          end else begin
            repeat ($urandom_range(1, 5)) txt = {txt, noise_char()};
          end
        end
      end else begin
        repeat ($urandom_range(1, 14)) txt = {txt, noise_char()};
      end
      send_text(txt);
      texts++;
      if (texts == 150) wait_drained();
    end

    // let the tail come out
    req_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("iso_date_to_epoch_days_top_tb OK");
    end else begin
      $display("iso_date_to_epoch_days_top_tb NOT OK");
    end
    $finish;
  end

endmodule
